[rtl/rfr_pkg.sv]
// -----------------------------------------------------------------------------
// rfr_pkg
// Shared types, codes and constants of the register frame receiver.
// -----------------------------------------------------------------------------
`default_nettype none

package rfr_pkg;

   localparam int MaxRegistersDefault = 64;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW = 64;

   localparam logic [7:0]  FrameHeader     = 8'h55;
   localparam logic [6:0]  RegCountDefault = 7'd64;
   localparam logic [23:0] TimeoutDefault  = 24'd200000;
   localparam logic [23:0] TickMax         = 24'hFFFFFF;

   // configuration register indexes
   typedef enum logic [CsrIndexW-1:0] {
      CSR_REG_COUNT = 2'd0,
      CSR_TX_MASK   = 2'd1,
      CSR_TIMEOUT   = 2'd2
   } csr_addr_type;

   // input transaction kinds
   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // frame position: which byte is expected next
   typedef enum logic [2:0] {
      POS_HEADER = 3'd0,
      POS_INDEX  = 3'd1,
      POS_DATA0  = 3'd2,
      POS_DATA1  = 3'd3,
      POS_DATA2  = 3'd4,
      POS_DATA3  = 3'd5,
      POS_CHECK  = 3'd6
   } pos_type;

   typedef struct packed {
      logic [6:0]  register_count;
      logic [23:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        write_valid;
      logic [5:0]  write_index;
      logic [31:0] write_value;
      logic        frame_good;
      logic        frame_bad;
      logic        link_timeout;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/register_frame_receiver_core.sv]
// -----------------------------------------------------------------------------
// register_frame_receiver_core
// Header-synchronized, checksum-protected register frame receiver.
// -----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_ready  req_command, req_rx_byte
//   rsp_     out        rsp_valid/rsp_ready  write, frame and timeout status
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// One transaction per cycle sustained while rsp_ready does not stall the
// result register; a result is presented once its request has passed the
// input register and then the result register.
// Reset clears the frame position, silence counter and timeout flag and
// loads the register defaults; captured frame bytes are not reset.
// A stalled result holds in the result register; the input register keeps
// taking a transaction while it is empty or the result register can advance.
// -----------------------------------------------------------------------------
`default_nettype none

module register_frame_receiver_core
   import rfr_pkg::*;
#(
   parameter int MAX_REGISTERS = MaxRegistersDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_command,
   input  wire logic [7:0]           req_rx_byte,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_write_valid,
   output logic      [5:0]           rsp_write_index,
   output logic      [31:0]          rsp_write_value,
   output logic                      rsp_frame_good,
   output logic                      rsp_frame_bad,
   output logic                      rsp_link_timeout,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [CsrDataW-1:0]  csr_data
);

   cfg_type                  cfg;
   logic [MAX_REGISTERS-1:0] tx_mask;
   rsp_type                  result;

   logic       in_valid_ff, in_valid_in;
   logic       in_command_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   logic req_fire, out_load, step;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   rfr_csr #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .tx_mask   (tx_mask)
   );

   // advance the result register when it is empty or being drained
   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_load;
   assign req_ready = !in_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the request payload until it is processed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_command_ff <= req_command;
         in_byte_ff    <= req_rx_byte;
      end
   end

   rfr_deframer #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_deframer (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .command (in_command_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .tx_mask (tx_mask),
      .result  (result)
   );

   // capture the result of the processed transaction
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_valid  = rsp_ff.write_valid;
   assign rsp_write_index  = rsp_ff.write_index;
   assign rsp_write_value  = rsp_ff.write_value;
   assign rsp_frame_good   = rsp_ff.frame_good;
   assign rsp_frame_bad    = rsp_ff.frame_bad;
   assign rsp_link_timeout = rsp_ff.link_timeout;

endmodule

`default_nettype wire

[rtl/rfr_csr.sv]
// -----------------------------------------------------------------------------
// rfr_csr
// Configuration registers: register count, transmit mask, timeout limit.
// -----------------------------------------------------------------------------
`default_nettype none

module rfr_csr
   import rfr_pkg::*;
#(
   parameter int MAX_REGISTERS = MaxRegistersDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [CsrIndexW-1:0]     csr_index,
   input  wire logic [CsrDataW-1:0]      csr_data,
   output cfg_type                       cfg,
   output logic      [MAX_REGISTERS-1:0] tx_mask
);

   logic [6:0]               reg_count_ff, reg_count_in;
   logic [MAX_REGISTERS-1:0] tx_mask_ff, tx_mask_in;
   logic [23:0]              timeout_ff, timeout_in;

   always_comb begin
      reg_count_in = reg_count_ff;
      tx_mask_in   = tx_mask_ff;
      timeout_in   = timeout_ff;
      if (csr_write) begin
         unique case (csr_addr_type'(csr_index))
            CSR_REG_COUNT: reg_count_in = csr_data[6:0];
            CSR_TX_MASK:   tx_mask_in   = csr_data[MAX_REGISTERS-1:0];
            CSR_TIMEOUT:   timeout_in   = csr_data[23:0];
            default: ; // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_count_ff <= RegCountDefault;
         tx_mask_ff   <= '0;
         timeout_ff   <= TimeoutDefault;
      end else begin
         reg_count_ff <= reg_count_in;
         tx_mask_ff   <= tx_mask_in;
         timeout_ff   <= timeout_in;
      end
   end

   assign cfg.register_count = reg_count_ff;
   assign cfg.timeout_ticks  = timeout_ff;
   assign tx_mask            = tx_mask_ff;

endmodule

`default_nettype wire

[rtl/rfr_deframer.sv]
// -----------------------------------------------------------------------------
// rfr_deframer
// Frame position tracking, byte capture, checksum, write decision and
// silence counter. Produces one result per step.
// -----------------------------------------------------------------------------
`default_nettype none

module rfr_deframer
   import rfr_pkg::*;
#(
   parameter int MAX_REGISTERS = MaxRegistersDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic                     command,
   input  wire logic [7:0]               rx_byte,
   input  wire cfg_type                  cfg,
   input  wire logic [MAX_REGISTERS-1:0] tx_mask,
   output rsp_type                       result
);

   localparam int MaskIdxW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
   localparam logic [7:0] RegLimit = 8'(MAX_REGISTERS);

   pos_type     pos_ff, pos_in;
   logic [7:0]  index_ff;
   logic [7:0]  data_ff [4];
   logic [23:0] silence_ff, silence_in;
   logic        flag_ff, flag_in;

   logic        byte_step, tick_step;
   logic [7:0]  sum;
   logic        frame_end, good, in_range, write_ok;
   logic [23:0] tick_next;

   assign byte_step = step && (cmd_type'(command) == CMD_BYTE);
   assign tick_step = step && (cmd_type'(command) == CMD_TICK);

   // next position
   always_comb begin
      pos_in = pos_ff;
      if (byte_step) begin
         unique case (pos_ff)
            POS_HEADER: if (rx_byte == FrameHeader) pos_in = POS_INDEX;
            POS_INDEX:  pos_in = POS_DATA0;
            POS_DATA0:  pos_in = POS_DATA1;
            POS_DATA1:  pos_in = POS_DATA2;
            POS_DATA2:  pos_in = POS_DATA3;
            POS_DATA3:  pos_in = POS_CHECK;
            POS_CHECK:  pos_in = POS_HEADER;
            default:    pos_in = POS_HEADER;
         endcase
      end
   end

   // checksum, write decision, silence counter
   always_comb begin
      sum       = index_ff + data_ff[0] + data_ff[1] + data_ff[2] + data_ff[3];
      frame_end = byte_step && (pos_ff == POS_CHECK);
      good      = frame_end && (sum == rx_byte);
      in_range  = (index_ff < {1'b0, cfg.register_count}) && (index_ff < RegLimit);
      write_ok  = good && in_range && !tx_mask[index_ff[MaskIdxW-1:0]];

      tick_next = (silence_ff != TickMax) ? silence_ff + 24'd1 : silence_ff;
      silence_in = silence_ff;
      flag_in    = flag_ff;
      if (tick_step) begin
         silence_in = tick_next;
         flag_in    = flag_ff || (tick_next > cfg.timeout_ticks);
      end else if (good) begin
         silence_in = '0;
         flag_in    = 1'b0;
      end

      result.write_valid  = write_ok;
      result.write_index  = write_ok ? index_ff[5:0] : 6'd0;
      result.write_value  = write_ok ? {data_ff[3], data_ff[2], data_ff[1], data_ff[0]}
                                     : 32'd0;
      result.frame_good   = good;
      result.frame_bad    = frame_end && !good;
      result.link_timeout = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_HEADER;
         silence_ff <= '0;
         flag_ff    <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         silence_ff <= silence_in;
         flag_ff    <= flag_in;
      end
   end

   // frame content, captured in place
   always_ff @(posedge clock) begin
      if (byte_step) begin
         case (pos_ff)
            POS_INDEX: index_ff   <= rx_byte;
            POS_DATA0: data_ff[0] <= rx_byte;
            POS_DATA1: data_ff[1] <= rx_byte;
            POS_DATA2: data_ff[2] <= rx_byte;
            POS_DATA3: data_ff[3] <= rx_byte;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire
